// ===== hdl/olt_pkg.sv =====
// Shared types and codes for the ordered list table.
// Used by olt_ctrl, olt_datapath, ordered_list_table and olt_checker.
`default_nettype none

package olt_pkg;

  // Operation selected by the mode field of an input word
  typedef enum logic [2:0] {
    MD_APPEND = 3'd0,
    MD_READ   = 3'd1,
    MD_REMOVE = 3'd2,
    MD_FIND   = 3'd3,
    MD_PURGE  = 3'd4,
    MD_CLEAR  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_SCAN,
    S_DONE
  } state_e;

  // Where an operation goes after its first execute cycle
  typedef enum logic [1:0] {
    RT_DONE,
    RT_READ,
    RT_SCAN
  } route_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [5:0]  position;
    logic [31:0] value;
    logic [6:0]  max_removals;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [5:0]  found_position;
    logic [6:0]  removed_count;
    logic [6:0]  list_length;
  } out_word_t;

  // Controller -> datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic rd_capture;
    logic scan_step;
    logic scan_end;
    logic load_out;
  } ctl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    route_e route;
    logic   scan_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/olt_ctrl.sv =====
// Sequencing state machine and output-word valid flag of the ordered list table.
// Depends on olt_pkg; drives olt_datapath through ctl_cmd_t.
`default_nettype none

module olt_ctrl
  import olt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_sts_t  sts_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        unique case (sts_i.route)
          RT_READ: state_d = S_RDWAIT;
          RT_SCAN: state_d = S_SCAN;
          default: state_d = S_DONE;
        endcase
      end
      S_RDWAIT: state_d = S_DONE;
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = (state_q == S_IDLE);
    cmd_o.latch        = (state_q == S_IDLE) && in_valid_i;
    cmd_o.exec         = (state_q == S_EXEC);
    cmd_o.rd_capture   = (state_q == S_RDWAIT);
    cmd_o.scan_step    = (state_q == S_SCAN);
    cmd_o.scan_end     = (state_q == S_SCAN) && sts_i.scan_done;
    cmd_o.load_out     = (state_q == S_DONE) && slot_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/olt_datapath.sv =====
// Entry memory, length register, scan pointers and result registers.
// Depends on olt_pkg; commanded by olt_ctrl.
`default_nettype none

module olt_datapath
  import olt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int ENTRY_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  ctl_cmd_t  cmd_i,
  output dp_sts_t   sts_o,
  output out_word_t out_data_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 6) ? CW : 6;
  localparam int VW = (ENTRY_BITS < 32) ? ENTRY_BITS : 32;

  logic [ENTRY_BITS-1:0] mem_q [CAPACITY];
  logic [ENTRY_BITS-1:0] rd_q;

  // command fields
  logic [2:0]  mode_q, mode_d;
  logic [5:0]  pos_q, pos_d;
  logic [31:0] val_q, val_d;
  logic [6:0]  max_q, max_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] r_q, r_d;
  logic [CW-1:0] w_q, w_d;
  logic [IW-1:0] pidx_q, pidx_d;
  logic          pend_q, pend_d;
  logic          first_q, first_d;
  logic          found_q, found_d;

  // result
  logic [1:0]  status_q, status_d;
  logic [31:0] rdata_q, rdata_d;
  logic [5:0]  fpos_q, fpos_d;
  logic [6:0]  removed_q, removed_d;
  out_word_t   out_q, out_d;

  logic                  mem_we, mem_re;
  logic [IW-1:0]         mem_wa, mem_ra;
  logic [ENTRY_BITS-1:0] mem_wd;
  logic [ENTRY_BITS-1:0] wr_val;
  logic [31:0]           rd_lo;
  logic [XW-1:0]         pos_ext;
  logic                  in_range, full, hit, drop;

  always_comb begin
    wr_val = '0;
    wr_val[VW-1:0] = val_q[VW-1:0];
    rd_lo = '0;
    rd_lo[VW-1:0] = rd_q[VW-1:0];
  end

  assign pos_ext  = XW'(pos_q);
  assign in_range = pos_ext < XW'(count_q);
  assign full     = count_q >= CW'(CAPACITY);
  assign hit      = (rd_q == wr_val);

  always_comb begin
    sts_o.route = RT_DONE;
    unique case (mode_q)
      MD_READ:   if (in_range) sts_o.route = RT_READ;
      MD_REMOVE: if (in_range) sts_o.route = RT_SCAN;
      MD_FIND:   sts_o.route = RT_SCAN;
      MD_PURGE:  sts_o.route = RT_SCAN;
      default:   sts_o.route = RT_DONE;
    endcase
  end

  assign sts_o.scan_done = (r_q >= count_q) && !pend_q;

  // remove at index drops the first entry scanned; remove matching drops hits up to the limit
  assign drop = (mode_q == MD_REMOVE) ? first_q : (hit && (removed_q < max_q));

  always_comb begin
    mode_d    = mode_q;
    pos_d     = pos_q;
    val_d     = val_q;
    max_d     = max_q;
    count_d   = count_q;
    r_d       = r_q;
    w_d       = w_q;
    pidx_d    = pidx_q;
    pend_d    = pend_q;
    first_d   = first_q;
    found_d   = found_q;
    status_d  = status_q;
    rdata_d   = rdata_q;
    fpos_d    = fpos_q;
    removed_d = removed_q;
    out_d     = out_q;
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = rd_q;
    mem_re    = 1'b0;
    mem_ra    = '0;

    if (cmd_i.latch) begin
      mode_d = in_data_i.mode;
      pos_d  = in_data_i.position;
      val_d  = in_data_i.value;
      max_d  = in_data_i.max_removals;
    end

    if (cmd_i.exec) begin
      status_d  = ST_OK;
      rdata_d   = '0;
      fpos_d    = '0;
      removed_d = '0;
      found_d   = 1'b0;
      first_d   = 1'b1;
      pend_d    = 1'b0;
      unique case (mode_q)
        MD_APPEND: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            mem_we  = 1'b1;
            mem_wa  = count_q[IW-1:0];
            mem_wd  = wr_val;
            count_d = count_q + CW'(1);
          end
        end
        MD_READ: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else begin
            mem_re = 1'b1;
            mem_ra = pos_ext[IW-1:0];
          end
        end
        MD_REMOVE: begin
          if (!in_range) begin
            status_d = ST_RANGE;
          end else begin
            r_d = pos_ext[CW-1:0];
            w_d = pos_ext[CW-1:0];
          end
        end
        MD_FIND: begin
          status_d = ST_NOTFOUND;
          r_d      = '0;
        end
        MD_PURGE: begin
          r_d = '0;
          w_d = '0;
        end
        MD_CLEAR: count_d = '0;
        default: ;
      endcase
    end

    if (cmd_i.rd_capture) rdata_d = rd_lo;

    if (cmd_i.scan_step) begin
      // issue the read of the next entry
      if (r_q < count_q) begin
        mem_re = 1'b1;
        mem_ra = r_q[IW-1:0];
        r_d    = r_q + CW'(1);
        pidx_d = r_q[IW-1:0];
        pend_d = 1'b1;
      end else begin
        pend_d = 1'b0;
      end
      // handle the entry read last cycle
      if (pend_q) begin
        first_d = 1'b0;
        if (mode_q == MD_FIND) begin
          if (hit && !found_q) begin
            found_d  = 1'b1;
            fpos_d   = 6'(pidx_q);
            status_d = ST_OK;
          end
        end else if (drop) begin
          if (mode_q == MD_PURGE) removed_d = removed_q + 7'd1;
        end else begin
          // compaction: write index never passes the read index
          mem_we = 1'b1;
          mem_wa = w_q[IW-1:0];
          mem_wd = rd_q;
          w_d    = w_q + CW'(1);
        end
      end
    end

    if (cmd_i.scan_end && ((mode_q == MD_REMOVE) || (mode_q == MD_PURGE))) begin
      count_d = w_q;
    end

    if (cmd_i.load_out) begin
      out_d.status         = status_q;
      out_d.read_data      = rdata_q;
      out_d.found_position = fpos_q;
      out_d.removed_count  = removed_q;
      out_d.list_length    = 7'(count_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    max_q     <= max_d;
    r_q       <= r_d;
    w_q       <= w_d;
    pidx_q    <= pidx_d;
    first_q   <= first_d;
    found_q   <= found_d;
    status_q  <= status_d;
    rdata_q   <= rdata_d;
    fpos_q    <= fpos_d;
    removed_q <= removed_d;
    out_q     <= out_d;
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/ordered_list_table.sv =====
// Ordered list table top level: olt_ctrl sequencer plus olt_datapath.
// Depends on olt_pkg, olt_ctrl and olt_datapath.
//
//  channel | valid      | ready       | word        | direction
//  --------+------------+-------------+-------------+----------
//  in      | in_valid_i | in_ready_o  | in_data_i   | into block
//  out     | out_valid_o| out_ready_i | out_data_o  | out of block
//
// One input word at a time; every word gives exactly one output word.
// Append, clear, unused modes and out-of-range requests go from execute
// straight to done; read at index waits in a read state for the entry
// memory; remove at index, find and remove matching scan from the index
// (or 0 for scans) to the end of the list, the entry memory doing one read
// and one write a cycle.
// Reset (async, active low) empties the list; entry memory is not cleared.
// A finished word sits in the output register while the next input word is
// taken; a stalled output only holds the block once the next result is ready.
`default_nettype none

module ordered_list_table
  import olt_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int ENTRY_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // sequencer: accept, execute, scan or read wait, then hand off a word
  olt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and scan logic; removals compact the list in one pass
  olt_datapath #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/olt_checker.sv =====
// Port-level checks for ordered_list_table, attached by bind.
// Depends on olt_pkg.
`default_nettype none

module olt_checker
  import olt_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_data_o
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // waiting input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while waiting");

  // one word at a time: ready drops right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  // full is only reported at capacity
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL) |->
      out_data_o.list_length == 7'(CAPACITY))
    else $error("full reported below capacity");

  // a range error reads and removes nothing
  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_RANGE) |->
      (out_data_o.read_data == 32'd0) && (out_data_o.removed_count == 7'd0))
    else $error("range error with data");

endmodule

bind ordered_list_table olt_checker #(.CAPACITY(CAPACITY)) u_olt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
